// ----- rtl/ecfp_pkg.sv -----
package ecfp_pkg;

    localparam int AXES        = 4;
    localparam int FRAME_BYTES = 128;

    localparam int POS_W   = 32;
    localparam int LEN_W   = $clog2(FRAME_BYTES);
    localparam int CNT_W   = 3;
    localparam int SLOTS   = 4;

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_ZERO = 1'b1;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_ZERO  = 1'b1;

    typedef struct packed {
        logic                             commit;
        logic [CNT_W-1:0]                 count;
        logic [SLOTS-1:0][POS_W-1:0]      value;
    } t_commit;

    typedef struct packed {
        logic                             kind;
        logic [CNT_W-1:0]                 count;
        logic [SLOTS-1:0][POS_W-1:0]      net;
    } t_result;

endpackage

// ----- rtl/ecfp_if.sv -----
interface ecfp_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] byte_value;
    logic [1:0] axis_index;

    modport source (output valid, output req_type, output byte_value, output axis_index,
                    input ready);
    modport sink   (input valid, input req_type, input byte_value, input axis_index,
                    output ready);
endinterface

interface ecfp_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [2:0]         axes_updated;
    logic signed [31:0] net_position_a;
    logic signed [31:0] net_position_b;
    logic signed [31:0] net_position_c;
    logic signed [31:0] net_position_d;

    modport source (output valid, output result_kind, output axes_updated,
                    output net_position_a, output net_position_b,
                    output net_position_c, output net_position_d,
                    input ready);
    modport sink   (input valid, input result_kind, input axes_updated,
                    input net_position_a, input net_position_b,
                    input net_position_c, input net_position_d,
                    output ready);
endinterface

// ----- rtl/ecfp_parser.sv -----
module ecfp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_req_type,
    input  logic [7:0]        i_byte,
    output ecfp_pkg::t_commit o_commit
);
    import ecfp_pkg::*;

    logic                        r_in_frame, n_in_frame;
    logic [LEN_W-1:0]            r_len, n_len;
    logic [CNT_W-1:0]            r_comma, n_comma;
    logic                        r_done, n_done;
    logic [POS_W-1:0]            r_acc, n_acc;
    logic [POS_W-1:0]            r_nacc, n_nacc;
    logic                        r_minus, n_minus;
    logic [SLOTS-1:0][POS_W-1:0] r_pend, n_pend;

    logic [POS_W-1:0] w_field;
    logic [3:0]       w_digit;
    logic [POS_W-1:0] w_acc10;
    logic [POS_W-1:0] w_nacc10;

    // negated copy runs alongside so a minus sign is only a select
    assign w_field  = r_minus ? r_nacc : r_acc;
    assign w_digit  = i_byte[3:0];
    assign w_acc10  = {r_acc[POS_W-4:0], 3'b000} + {r_acc[POS_W-2:0], 1'b0};
    assign w_nacc10 = {r_nacc[POS_W-4:0], 3'b000} + {r_nacc[POS_W-2:0], 1'b0};

    always_comb begin
        n_in_frame = r_in_frame;
        n_len      = r_len;
        n_comma    = r_comma;
        n_done     = r_done;
        n_acc      = r_acc;
        n_nacc     = r_nacc;
        n_minus    = r_minus;
        n_pend     = r_pend;
        o_commit   = '0;
        o_commit.value = r_pend;

        if (i_req_type == REQ_BYTE) begin
            if (i_byte == CH_BANG || i_byte == CH_GT) begin
                n_in_frame = 1'b1;
                n_len      = LEN_W'(1);
                n_comma    = '0;
                n_done     = 1'b0;
                n_acc      = '0;
                n_nacc     = '0;
                n_minus    = 1'b0;
            end else if (r_in_frame && r_len < LEN_W'(FRAME_BYTES - 1)) begin
                n_len = r_len + LEN_W'(1);
                if (i_byte == CH_CR || i_byte == CH_LF) begin
                    if (r_comma < CNT_W'(SLOTS))
                        n_pend[r_comma[1:0]] = w_field;
                    o_commit.commit = 1'b1;
                    o_commit.value  = n_pend;
                    if (r_comma >= CNT_W'(AXES))
                        o_commit.count = CNT_W'(AXES);
                    else
                        o_commit.count = r_comma + CNT_W'(1);
                    n_in_frame = 1'b0;
                    n_len      = '0;
                    n_comma    = '0;
                    n_done     = 1'b0;
                    n_acc      = '0;
                    n_nacc     = '0;
                    n_minus    = 1'b0;
                end else if (!r_done) begin
                    if (i_byte == CH_COMMA) begin
                        n_pend[r_comma[1:0]] = w_field;
                        n_acc   = '0;
                        n_nacc  = '0;
                        n_minus = 1'b0;
                        n_comma = r_comma + CNT_W'(1);
                        n_done  = (n_comma >= CNT_W'(SLOTS));
                    end else if (i_byte == CH_MINUS) begin
                        n_minus = 1'b1;
                    end else if (i_byte >= CH_ZERO && i_byte <= CH_NINE) begin
                        n_acc  = w_acc10 + POS_W'(w_digit);
                        n_nacc = w_nacc10 - POS_W'(w_digit);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_len      <= '0;
            r_comma    <= '0;
            r_done     <= 1'b0;
            r_acc      <= '0;
            r_nacc     <= '0;
            r_minus    <= 1'b0;
            r_pend     <= '0;
        end else if (i_en) begin
            r_in_frame <= n_in_frame;
            r_len      <= n_len;
            r_comma    <= n_comma;
            r_done     <= n_done;
            r_acc      <= n_acc;
            r_nacc     <= n_nacc;
            r_minus    <= n_minus;
            r_pend     <= n_pend;
        end
    end

endmodule

// ----- rtl/ecfp_axes.sv -----
module ecfp_axes (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_en,
    input  logic                                           i_zero,
    input  logic [1:0]                                     i_axis,
    input  ecfp_pkg::t_commit                              i_commit,
    output logic [ecfp_pkg::SLOTS-1:0][ecfp_pkg::POS_W-1:0] o_net
);
    import ecfp_pkg::*;

    logic [AXES-1:0][POS_W-1:0] r_pos, n_pos;
    logic [AXES-1:0][POS_W-1:0] r_off, n_off;

    always_comb begin
        n_pos = r_pos;
        n_off = r_off;
        o_net = '0;
        for (int i = 0; i < AXES; i++) begin
            if (i_commit.commit && CNT_W'(i) < i_commit.count)
                n_pos[i] = i_commit.value[i];
            if (i_zero && i_axis == 2'(i))
                n_off[i] = r_pos[i];
            // report follows the update of this beat
            o_net[i] = n_pos[i] - n_off[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_off <= '0;
        end else if (i_en) begin
            r_pos <= n_pos;
            r_off <= n_off;
        end
    end

endmodule

// ----- rtl/encoder_csv_frame_parser_unit.sv -----
// channel | dir | beat payload
// i_in    | in  | req_type, byte_value, axis_index
// o_out   | out | result_kind, axes_updated, net_position_a..d
//
// one beat per cycle sustained while the result is not stalled; each result is registered in the result register
// path: input register, then parser and axis update into the result register
// bytes that make no result leave the input register without touching o_out
// a stalled result holds the pipe only while the input register is also full
// i_rst_n is synchronous, active low, clears all frame and axis state to zero
module encoder_csv_frame_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ecfp_in_if.sink    i_in,
    ecfp_out_if.source o_out
);
    import ecfp_pkg::*;

    logic       r_in_valid;
    logic       r_in_type;
    logic [7:0] r_in_byte;
    logic [1:0] r_in_axis;

    logic    r_out_valid;
    t_result r_out;

    logic                        w_adv;
    t_commit                     w_commit;
    logic [SLOTS-1:0][POS_W-1:0] w_net;

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    ecfp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_req_type (r_in_type),
        .i_byte     (r_in_byte),
        .o_commit   (w_commit)
    );

    ecfp_axes u_axes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_zero   (r_in_type == REQ_ZERO),
        .i_axis   (r_in_axis),
        .i_commit (w_commit),
        .o_net    (w_net)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready) begin
            r_in_type <= i_in.req_type;
            r_in_byte <= i_in.byte_value;
            r_in_axis <= i_in.axis_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && (r_in_type == REQ_ZERO || w_commit.commit)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv && (r_in_type == REQ_ZERO || w_commit.commit)) begin
            r_out.kind  <= (r_in_type == REQ_ZERO) ? KIND_ZERO : KIND_FRAME;
            r_out.count <= (r_in_type == REQ_ZERO) ? '0 : w_commit.count;
            r_out.net   <= w_net;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_kind    = r_out.kind;
    assign o_out.axes_updated   = r_out.count;
    assign o_out.net_position_a = r_out.net[0];
    assign o_out.net_position_b = r_out.net[1];
    assign o_out.net_position_c = r_out.net[2];
    assign o_out.net_position_d = r_out.net[3];

endmodule
